### src/segregated_free_list_allocator_assert.svh
// assertion macros for the segregated free list allocator
// used by the top level; expects clk and rst_n in the calling scope
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SFLA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfla check failed");

// next-cycle implication, disabled during reset
`define SFLA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfla check failed");

`endif

### src/sfla_pkg.sv
// shared types, constants and codes of the segregated free list allocator
// no dependencies
`default_nettype none

package sfla_pkg;

  // sizing
  localparam int NUM_CLASSES  = 4;
  localparam int REGION_BYTES = 4096;
  localparam int WORD_BYTES   = 8;
  localparam int LINK_DEPTH   = (REGION_BYTES + WORD_BYTES - 1) / WORD_BYTES;
  localparam int LINK_AW      = $clog2(LINK_DEPTH);
  localparam int WB_SH        = $clog2(WORD_BYTES);
  localparam int CLS_W        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SIZE_W       = 13;
  localparam int COUNT_W      = 8;
  localparam int HEAD_W       = 13;
  localparam int PROD_W       = SIZE_W + COUNT_W;
  localparam int TOTAL_W      = PROD_W + 2;
  localparam int CFG_IDX_W    = 4;

  localparam logic [HEAD_W-1:0] NULL_CODE = HEAD_W'(REGION_BYTES);
  localparam logic [CLS_W-1:0]  CLS_LAST  = CLS_W'(NUM_CLASSES - 1);

  // operation codes
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NULL      = 3'd3;
  localparam logic [2:0] ST_OUTSIDE   = 3'd4;
  localparam logic [2:0] ST_BAD       = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE0  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE3  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT0 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT3 = 4'd7;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd8;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] request_size;
    logic [15:0] address;
    logic        is_null;
  } in_item_t;

  typedef struct packed {
    logic [11:0] slot_address;
    logic [2:0]  status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_POP, S_MUL, S_ACC, S_CHK, S_WALK, S_BDONE
  } state_t;

  typedef enum logic [1:0] {
    RES_LOOK, RES_POP, RES_BAD, RES_DONE
  } res_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     mul;
    logic     acc;
    logic     clr_heads;
    logic     init_walk;
    logic     walk;
    logic     look_rd;
    logic     commit_look;
    logic     commit_pop;
    logic     emit;
    res_sel_t res_sel;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] in_op;
    logic       go_pop;
    logic       layout_bad;
    logic       cls_last;
    logic       walk_done;
    logic       out_free;
  } dp_stat_t;

  // reset slot size of a class: sixteen bytes doubled per class
  function automatic logic [SIZE_W-1:0] size_reset(input int c);
    return SIZE_W'(16 << c);
  endfunction

endpackage

`default_nettype wire

### src/sfla_ctrl.sv
// controller state machine of the allocator
// depends on sfla_pkg; drives commands into sfla_dp
`default_nettype none

module sfla_ctrl import sfla_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (stat.in_op == OP_INIT) ? S_MUL : S_LOOK;
        end
      end
      S_LOOK: begin
        if (stat.go_pop) begin
          state_nxt = S_POP;
        end else if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_POP: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_MUL: state_nxt = S_ACC;
      S_ACC: state_nxt = stat.cls_last ? S_CHK : S_MUL;
      S_CHK: begin
        if (!stat.layout_bad) begin
          state_nxt = S_WALK;
        end else if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        if (stat.walk_done) state_nxt = S_BDONE;
      end
      S_BDONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    cmd.res_sel = RES_LOOK;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_LOOK: begin
        cmd.look_rd = 1'b1;
        if (!stat.go_pop && stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.commit_look = 1'b1;
          cmd.res_sel     = RES_LOOK;
        end
      end
      S_POP: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.commit_pop = 1'b1;
          cmd.res_sel    = RES_POP;
        end
      end
      S_MUL: cmd.mul = 1'b1;
      S_ACC: cmd.acc = 1'b1;
      S_CHK: begin
        cmd.clr_heads = 1'b1;
        if (!stat.layout_bad) begin
          cmd.init_walk = 1'b1;
        end else if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.res_sel = RES_BAD;
        end
      end
      S_WALK: cmd.walk = 1'b1;
      S_BDONE: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.res_sel = RES_DONE;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### src/sfla_dp.sv
// datapath of the allocator: config registers, list heads, link memory,
// layout sum and walk counters, output register; depends on sfla_pkg
`default_nettype none

module sfla_dp import sfla_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_data,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat
);

  logic [SIZE_W-1:0]  size_r  [NUM_CLASSES];
  logic [COUNT_W-1:0] count_r [NUM_CLASSES];
  logic [HEAD_W-1:0]  head_r  [NUM_CLASSES];
  logic [HEAD_W-1:0]  link_mem [LINK_DEPTH];

  in_item_t           item_r;
  logic [PROD_W-1:0]  prod_r;
  logic [TOTAL_W-1:0] total_r;
  logic [CLS_W-1:0]   cls_r;
  logic [COUNT_W-1:0] j_r;
  logic [HEAD_W-1:0]  a_r;
  logic [HEAD_W-1:0]  rd_data_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               found;
  logic [CLS_W-1:0]   fcls;
  logic [HEAD_W-1:0]  head_sel;
  logic [2:0]         look_status;
  logic               go_pop;
  logic               push_ok;
  logic [COUNT_W-1:0] cur_n;
  logic [SIZE_W-1:0]  cur_sz;
  logic               slot_step;
  logic [HEAD_W-1:0]  a_sum;
  logic [HEAD_W-1:0]  link_val;
  logic               mem_we;
  logic [LINK_AW-1:0] mem_wa;
  logic [HEAD_W-1:0]  mem_wd;
  logic               out_free;
  out_item_t          res;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        size_r[c]  <= size_reset(c);
        count_r[c] <= COUNT_RESET;
      end
    end else if (cfg_valid) begin
      if (cfg_index inside {[REG_SIZE0:REG_SIZE3]}) begin
        size_r[CLS_W'(cfg_index - REG_SIZE0)] <= cfg_data;
      end else if (cfg_index inside {[REG_COUNT0:REG_COUNT3]}) begin
        count_r[CLS_W'(cfg_index - REG_COUNT0)] <= cfg_data[COUNT_W-1:0];
      end
    end
  end

  // first class whose slot size covers the request
  always_comb begin
    found = 1'b0;
    fcls  = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (16'(size_r[c]) >= item_r.request_size) begin
        found = 1'b1;
        fcls  = CLS_W'(c);
      end
    end
  end

  assign head_sel = head_r[fcls];

  // allocate / free checks
  always_comb begin
    look_status = ST_OK;
    go_pop      = 1'b0;
    push_ok     = 1'b0;
    case (item_r.operation)
      OP_ALLOC: begin
        if (!found) begin
          look_status = ST_TOO_LARGE;
        end else if (head_sel == NULL_CODE) begin
          look_status = ST_EMPTY;
        end else begin
          go_pop = 1'b1;
        end
      end
      OP_FREE: begin
        if (item_r.is_null) begin
          look_status = ST_NULL;
        end else if (32'(item_r.address) >= REGION_BYTES) begin
          look_status = ST_OUTSIDE;
        end else if (!found) begin
          look_status = ST_TOO_LARGE;
        end else begin
          push_ok = 1'b1;
        end
      end
      default: look_status = ST_OK;
    endcase
  end

  // list build walk: one slot per cycle
  assign cur_n     = count_r[cls_r];
  assign cur_sz    = size_r[cls_r];
  assign slot_step = (j_r != cur_n);
  assign a_sum     = a_r + cur_sz;
  assign link_val  = ((9'(j_r) + 9'd1) < 9'(cur_n)) ? a_sum : NULL_CODE;

  // link memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = a_r[LINK_AW+WB_SH-1:WB_SH];
    mem_wd = link_val;
    if (cmd.walk && slot_step && (32'(a_r) < REGION_BYTES)) begin
      mem_we = 1'b1;
    end else if (cmd.commit_look && push_ok) begin
      mem_we = 1'b1;
      mem_wa = item_r.address[LINK_AW+WB_SH-1:WB_SH];
      mem_wd = head_sel;
    end
  end

  // link memory, registered read of the head's link
  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_wa] <= mem_wd;
    if (cmd.look_rd) rd_data_r <= link_mem[head_sel[LINK_AW+WB_SH-1:WB_SH]];
  end

  // request latch and layout sum
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.mul) prod_r <= PROD_W'(cur_sz) * PROD_W'(cur_n);
  end

  // class, slot and sum counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r   <= '0;
      j_r     <= '0;
      a_r     <= '0;
      total_r <= '0;
    end else if (cmd.load) begin
      cls_r   <= '0;
      total_r <= '0;
    end else if (cmd.acc) begin
      total_r <= total_r + TOTAL_W'(prod_r);
      cls_r   <= cls_r + CLS_W'(1);
    end else if (cmd.init_walk) begin
      cls_r <= '0;
      j_r   <= '0;
      a_r   <= '0;
    end else if (cmd.walk) begin
      if (slot_step) begin
        j_r <= j_r + COUNT_W'(1);
        a_r <= a_sum;
      end else if (cls_r != CLS_LAST) begin
        cls_r <= cls_r + CLS_W'(1);
        j_r   <= '0;
      end
    end
  end

  // free list heads
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_heads) begin
      for (int c = 0; c < NUM_CLASSES; c++) head_r[c] <= NULL_CODE;
    end else if (cmd.walk && slot_step && (j_r == '0)) begin
      head_r[cls_r] <= a_r;
    end else if (cmd.commit_look && push_ok) begin
      head_r[fcls] <= item_r.address[HEAD_W-1:0];
    end else if (cmd.commit_pop) begin
      head_r[fcls] <= rd_data_r;
    end
  end

  // result select
  always_comb begin
    res = '0;
    case (cmd.res_sel)
      RES_LOOK: res.status = look_status;
      RES_POP:  res.slot_address = head_sel[11:0];
      RES_BAD:  res.status = ST_BAD;
      RES_DONE: res.status = ST_OK;
      default:  res = '0;
    endcase
  end

  // output register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status to controller
  always_comb begin
    stat            = '0;
    stat.in_op      = in_data.operation;
    stat.go_pop     = go_pop;
    stat.layout_bad = 32'(total_r) > REGION_BYTES;
    stat.cls_last   = (cls_r == CLS_LAST);
    stat.walk_done  = (cls_r == CLS_LAST) && !slot_step;
    stat.out_free   = out_free;
  end

endmodule

`default_nettype wire

### src/segregated_free_list_allocator.sv
// top level of the segregated free list allocator
// depends on sfla_pkg, sfla_ctrl, sfla_dp and the assertion macro header
//
//   channel  direction  handshake              payload
//   in_      request    in_valid / in_ready    in_item_t
//   out_     result     out_valid / out_ready  out_item_t
//   cfg_     write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// allocate steps through accept, head lookup with link read, and pop;
// free and rejected requests end at the lookup: the registered link read sets this.
// list build sums size times count per class, checks the total, then links one slot per cycle.
// synchronous active-low reset empties every list; link memory is not cleared.
// a result waiting on out_ready stalls only the following request's finish.
`default_nettype none
`include "segregated_free_list_allocator_assert.svh"

module segregated_free_list_allocator import sfla_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller
  sfla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  sfla_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  // a request is worked on alone
  `SFLA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // a pending result is never overwritten
  `SFLA_ASSERT_NOW(a_emit_when_free, cmd.emit, !out_valid || out_ready)
  // list heads change on a pop or push only together with its result
  `SFLA_ASSERT_NOW(a_commit_with_result, cmd.commit_pop || cmd.commit_look, cmd.emit)
  // a result goes out only once the request has left the idle state
  `SFLA_ASSERT_NOW(a_no_emit_idle, in_ready, !cmd.emit)

endmodule

`default_nettype wire
